@@ rtl/rcsp_pkg.sv @@
// Shared types, constants and helpers for the RESP command stream parser.
// Used by rcsp_core and resp_command_stream_parser; depends on nothing else.
package rcsp_pkg;

   localparam int LENGTH_BITS_DEFAULT = 32;
   localparam int ARG_W               = 20;
   localparam int COUNT_W             = 32;
   localparam int BULK_MAX_W          = 31;
   localparam int ELEM_MAX_W          = 21;
   localparam int CSR_ADDR_W          = 3;
   localparam int CSR_DATA_W          = 32;
   localparam int RSP_DATA_W          = 32;

   localparam logic [BULK_MAX_W-1:0] MAX_BULK_RESET = 31'd536870912;
   localparam logic [ELEM_MAX_W-1:0] MAX_ELEM_RESET = 21'd1048576;

   // Register index as seen at paddr[2].
   localparam logic REG_MAX_BULK = 1'b0;
   localparam logic REG_MAX_ELEM = 1'b1;

   localparam logic [7:0] CH_PLUS   = 8'h2b;
   localparam logic [7:0] CH_MINUS  = 8'h2d;
   localparam logic [7:0] CH_COLON  = 8'h3a;
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_STAR   = 8'h2a;
   localparam logic [7:0] CH_CR     = 8'h0d;
   localparam logic [7:0] CH_LF     = 8'h0a;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_ELEM,
      PH_LINE,
      PH_LEN,
      PH_PAYLOAD,
      PH_TRAIL1,
      PH_TRAIL2
   } phase_type;

   typedef enum logic [1:0] {
      KIND_NONE,
      KIND_LINE,
      KIND_BULK,
      KIND_ARRAY
   } kind_type;

   typedef struct packed {
      logic [BULK_MAX_W-1:0] max_bulk_length;
      logic [ELEM_MAX_W-1:0] max_elements;
   } cfg_type;

   typedef struct packed {
      logic             has_byte;
      logic [7:0]       payload_byte;
      logic [ARG_W-1:0] arg_index;
      logic             arg_end;
      logic             command_end;
      logic             command_ok;
      logic             protocol_error;
   } res_type;

   function automatic logic is_marker(input logic [7:0] b);
      return (b == CH_PLUS) || (b == CH_MINUS) || (b == CH_COLON) ||
             (b == CH_DOLLAR) || (b == CH_STAR);
   endfunction

endpackage

@@ rtl/rcsp_core.sv @@
// Parser state and per-byte update for the RESP command stream parser.
// Depends on rcsp_pkg; instantiated by resp_command_stream_parser.
module rcsp_core #(
   parameter int LENGTH_BITS = rcsp_pkg::LENGTH_BITS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  logic [7:0]        stream_byte,
   input  rcsp_pkg::cfg_type cfg,
   output logic              res_valid,
   output rcsp_pkg::res_type res
);

   localparam int AW     = LENGTH_BITS + 4;
   localparam int BCMP_W = (LENGTH_BITS > rcsp_pkg::BULK_MAX_W) ? LENGTH_BITS
                                                                : rcsp_pkg::BULK_MAX_W;
   localparam int ECMP_W = (LENGTH_BITS > rcsp_pkg::ELEM_MAX_W) ? LENGTH_BITS
                                                                : rcsp_pkg::ELEM_MAX_W;
   localparam int CW     = rcsp_pkg::COUNT_W;
   localparam int ARW    = rcsp_pkg::ARG_W;

   rcsp_pkg::phase_type phase_ff, phase_pre, phase_in;
   rcsp_pkg::kind_type  kind_ff, kind_pre, kind_in;
   logic [LENGTH_BITS-1:0] acc_ff, acc_pre, acc_in;
   logic [LENGTH_BITS-1:0] left_ff, left_pre, left_in;
   logic [CW-1:0]          elem_ff, elem_pre, elem_in;
   logic [ARW-1:0]         arg_ff, arg_pre, arg_in;
   logic neg_ff, neg_pre, neg_in;
   logic digit_ff, digit_pre, digit_in;
   logic inside_ff, inside_pre, inside_in;
   logic good_ff, good_pre, good_in;
   logic cr_ff, cr_pre, cr_in;

   logic err, fin, emit_data, emit_empty;

   logic [AW-1:0]          acc_ext, acc_raw;
   logic [LENGTH_BITS-1:0] acc_digit;
   logic                   is_null, sat_hit, bulk_over, elem_over, is_digit;
   logic [LENGTH_BITS-1:0] n_len, left_dec;
   logic [CW:0]            elem_sum;
   logic [CW-1:0]          elem_add, elem_fin;
   logic                   fin_done;
   logic [ARW-1:0]         arg_inc;

   // Decimal accumulate as (x << 3) + (x << 1) + digit, saturating at all ones.
   assign acc_ext   = AW'(acc_ff);
   assign acc_raw   = (acc_ext << 3) + (acc_ext << 1) + AW'(stream_byte[3:0]);
   assign acc_digit = (|acc_raw[AW-1:LENGTH_BITS]) ? '1 : acc_raw[LENGTH_BITS-1:0];
   assign is_digit  = (stream_byte >= rcsp_pkg::CH_ZERO) &&
                      (stream_byte <= rcsp_pkg::CH_NINE);

   assign is_null   = neg_ff && (acc_ff != '0);
   assign n_len     = is_null ? '0 : acc_ff;
   assign sat_hit   = (acc_ff == '1);
   assign bulk_over = BCMP_W'(n_len) > BCMP_W'(cfg.max_bulk_length);
   assign elem_over = ECMP_W'(n_len) > ECMP_W'(cfg.max_elements);
   assign elem_sum  = {1'b0, elem_ff} + (CW+1)'(n_len);
   assign elem_add  = elem_sum[CW] ? '1 : elem_sum[CW-1:0];
   assign left_dec  = left_ff - LENGTH_BITS'(left_ff != '0);

   assign elem_fin  = elem_pre - CW'(elem_pre != '0);
   assign fin_done  = (elem_fin == '0);
   assign arg_inc   = (arg_ff == '1) ? arg_ff : arg_ff + ARW'(1);

   // Per-byte decode: partial next state plus the events it raises.
   always_comb begin
      phase_pre  = phase_ff;
      kind_pre   = kind_ff;
      acc_pre    = acc_ff;
      left_pre   = left_ff;
      elem_pre   = elem_ff;
      arg_pre    = arg_ff;
      neg_pre    = neg_ff;
      digit_pre  = digit_ff;
      inside_pre = inside_ff;
      good_pre   = good_ff;
      cr_pre     = cr_ff;
      err        = 1'b0;
      fin        = 1'b0;
      emit_data  = 1'b0;
      emit_empty = 1'b0;

      unique case (phase_ff)
         rcsp_pkg::PH_ELEM, rcsp_pkg::PH_IDLE: begin
            phase_pre = rcsp_pkg::PH_IDLE;
            if (rcsp_pkg::is_marker(stream_byte)) begin
               cr_pre    = 1'b0;
               acc_pre   = '0;
               neg_pre   = 1'b0;
               digit_pre = 1'b0;
               if (stream_byte == rcsp_pkg::CH_DOLLAR) begin
                  kind_pre  = rcsp_pkg::KIND_BULK;
                  phase_pre = rcsp_pkg::PH_LEN;
               end else if (stream_byte == rcsp_pkg::CH_STAR) begin
                  kind_pre  = rcsp_pkg::KIND_ARRAY;
                  phase_pre = rcsp_pkg::PH_LEN;
               end else begin
                  kind_pre  = rcsp_pkg::KIND_LINE;
                  phase_pre = rcsp_pkg::PH_LINE;
               end
            end else if (phase_ff == rcsp_pkg::PH_ELEM) begin
               err = 1'b1;
            end
         end
         rcsp_pkg::PH_LINE: begin
            if (cr_ff && (stream_byte == rcsp_pkg::CH_LF)) begin
               cr_pre = 1'b0;
               if (inside_ff) begin
                  good_pre = 1'b0;
                  fin      = 1'b1;
               end else begin
                  phase_pre = rcsp_pkg::PH_IDLE;
               end
            end else begin
               cr_pre = (stream_byte == rcsp_pkg::CH_CR);
            end
         end
         rcsp_pkg::PH_LEN: begin
            if (cr_ff) begin
               cr_pre = 1'b0;
               if ((stream_byte != rcsp_pkg::CH_LF) || !digit_ff ||
                   (!is_null && sat_hit)) begin
                  err = 1'b1;
               end else if (kind_ff == rcsp_pkg::KIND_BULK) begin
                  if (!is_null && bulk_over) begin
                     err = 1'b1;
                  end else if (is_null) begin
                     if (inside_ff) fin = 1'b1;
                     else phase_pre = rcsp_pkg::PH_IDLE;
                  end else begin
                     left_pre  = n_len;
                     phase_pre = (n_len == '0) ? rcsp_pkg::PH_TRAIL1
                                               : rcsp_pkg::PH_PAYLOAD;
                  end
               end else if (elem_over) begin
                  err = 1'b1;
               end else if (inside_ff) begin
                  // A nested array header is itself one element of the command.
                  good_pre = 1'b0;
                  elem_pre = elem_add;
                  fin      = 1'b1;
               end else begin
                  arg_pre  = '0;
                  good_pre = 1'b1;
                  if (n_len == '0) begin
                     phase_pre  = rcsp_pkg::PH_IDLE;
                     emit_empty = 1'b1;
                  end else begin
                     elem_pre   = CW'(n_len);
                     inside_pre = 1'b1;
                     phase_pre  = rcsp_pkg::PH_ELEM;
                  end
               end
            end else if (stream_byte == rcsp_pkg::CH_CR) begin
               cr_pre = 1'b1;
            end else if (stream_byte == rcsp_pkg::CH_MINUS) begin
               if (digit_ff || neg_ff) err = 1'b1;
               else neg_pre = 1'b1;
            end else if (is_digit) begin
               acc_pre   = acc_digit;
               digit_pre = 1'b1;
            end else begin
               err = 1'b1;
            end
         end
         rcsp_pkg::PH_PAYLOAD: begin
            left_pre  = left_dec;
            if (left_dec == '0) phase_pre = rcsp_pkg::PH_TRAIL1;
            emit_data = inside_ff;
         end
         rcsp_pkg::PH_TRAIL1: begin
            phase_pre = rcsp_pkg::PH_TRAIL2;
         end
         rcsp_pkg::PH_TRAIL2: begin
            if (inside_ff) fin = 1'b1;
            else phase_pre = rcsp_pkg::PH_IDLE;
         end
         default: begin
            phase_pre = rcsp_pkg::PH_IDLE;
         end
      endcase
   end

   // Next state: element close and error abort applied on top of the decode.
   always_comb begin
      phase_in  = phase_pre;
      kind_in   = kind_pre;
      acc_in    = acc_pre;
      left_in   = left_pre;
      elem_in   = elem_pre;
      arg_in    = arg_pre;
      neg_in    = neg_pre;
      digit_in  = digit_pre;
      inside_in = inside_pre;
      good_in   = good_pre;
      cr_in     = cr_pre;
      if (fin) begin
         arg_in    = arg_inc;
         elem_in   = elem_fin;
         phase_in  = fin_done ? rcsp_pkg::PH_IDLE : rcsp_pkg::PH_ELEM;
         inside_in = inside_pre && !fin_done;
      end
      if (err) begin
         phase_in  = rcsp_pkg::PH_IDLE;
         kind_in   = rcsp_pkg::KIND_NONE;
         acc_in    = '0;
         left_in   = '0;
         elem_in   = '0;
         arg_in    = '0;
         neg_in    = 1'b0;
         digit_in  = 1'b0;
         inside_in = 1'b0;
         good_in   = 1'b1;
         cr_in     = 1'b0;
      end
   end

   // Result item for this byte.
   always_comb begin
      res       = '0;
      res_valid = step && (err || fin || emit_data || emit_empty);
      if (err) begin
         res.protocol_error = 1'b1;
         res.command_end    = inside_ff;
         res.arg_index      = arg_ff;
      end else if (fin) begin
         res.arg_index   = arg_ff;
         res.arg_end     = 1'b1;
         res.command_end = fin_done;
         res.command_ok  = fin_done && good_pre;
      end else if (emit_data) begin
         res.has_byte     = 1'b1;
         res.payload_byte = stream_byte;
         res.arg_index    = arg_ff;
      end else if (emit_empty) begin
         res.command_end = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= rcsp_pkg::PH_IDLE;
         kind_ff   <= rcsp_pkg::KIND_NONE;
         acc_ff    <= '0;
         left_ff   <= '0;
         elem_ff   <= '0;
         arg_ff    <= '0;
         neg_ff    <= 1'b0;
         digit_ff  <= 1'b0;
         inside_ff <= 1'b0;
         good_ff   <= 1'b1;
         cr_ff     <= 1'b0;
      end else if (step) begin
         phase_ff  <= phase_in;
         kind_ff   <= kind_in;
         acc_ff    <= acc_in;
         left_ff   <= left_in;
         elem_ff   <= elem_in;
         arg_ff    <= arg_in;
         neg_ff    <= neg_in;
         digit_ff  <= digit_in;
         inside_ff <= inside_in;
         good_ff   <= good_in;
         cr_ff     <= cr_in;
      end
   end

endmodule

@@ rtl/resp_command_stream_parser.sv @@
// RESP command stream parser, top level: byte stream in, argument stream out.
// Depends on rcsp_pkg and rcsp_core.
//
// The req_ channel takes one raw request byte per transfer. The rsp_ channel
// returns argument bytes with their index (rsp_tuser = 1), element-end markers,
// and a command-end marker on rsp_tlast carrying the command verdict or a
// protocol error. Many bytes (markers, length digits, line values, trailers)
// produce no result transfer at all.
// Throughput is one byte per cycle while req_tready is high: the whole parse
// update for a byte is one combinational step on the state registers in
// rcsp_core. Each result is registered in the output queue before rsp_.
// Results go into a two-entry output queue, so req_tready depends only on
// queue occupancy; when the receiver stalls, input keeps flowing until both
// entries hold results, then req_tready drops.
// Reset clears the parser to idle, empties the queue and restores the limit
// registers: max_bulk_length 536870912 at address 0x0, max_elements 1048576
// at address 0x4. Limits should be changed only while the stream is idle.
module resp_command_stream_parser #(
   parameter int LENGTH_BITS = rcsp_pkg::LENGTH_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [7:0]                         req_tdata,  // [7:0] stream_byte
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [7:0] payload_byte, [27:8] arg_index, [28] arg_end, [29] command_ok,
   // [30] protocol_error, [31] zero
   output logic [rcsp_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                               rsp_tuser,  // [0] has_byte
   output logic                               rsp_tlast,  // command_end
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [rcsp_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [rcsp_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [rcsp_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                               csr_pready
);

   rcsp_pkg::cfg_type cfg_ff;
   logic              csr_wr;

   logic              step;
   logic              core_valid;
   rcsp_pkg::res_type core_res;

   rcsp_pkg::res_type slot0_ff, slot1_ff;
   logic [1:0]        count_ff;
   logic              push, pop;

   // Configuration registers.
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_bulk_length <= rcsp_pkg::MAX_BULK_RESET;
         cfg_ff.max_elements    <= rcsp_pkg::MAX_ELEM_RESET;
      end else if (csr_wr) begin
         if (csr_paddr[2] == rcsp_pkg::REG_MAX_BULK) begin
            cfg_ff.max_bulk_length <= csr_pwdata[rcsp_pkg::BULK_MAX_W-1:0];
         end else begin
            cfg_ff.max_elements <= csr_pwdata[rcsp_pkg::ELEM_MAX_W-1:0];
         end
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         rcsp_pkg::REG_MAX_BULK:
            csr_prdata = rcsp_pkg::CSR_DATA_W'(cfg_ff.max_bulk_length);
         rcsp_pkg::REG_MAX_ELEM:
            csr_prdata = rcsp_pkg::CSR_DATA_W'(cfg_ff.max_elements);
         default:
            csr_prdata = '0;
      endcase
   end

   // Parser.
   assign req_tready = (count_ff != 2'd2);
   assign step       = req_tvalid && req_tready;

   rcsp_core #(
      .LENGTH_BITS(LENGTH_BITS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .stream_byte(req_tdata),
      .cfg        (cfg_ff),
      .res_valid  (core_valid),
      .res        (core_res)
   );

   // Two-entry result queue; slot0 is the head.
   assign push = core_valid;
   assign pop  = rsp_tvalid && rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_ff + 2'(push) - 2'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         slot0_ff <= (push && (count_ff == 2'd1)) ? core_res : slot1_ff;
         if (push && (count_ff == 2'd2)) slot1_ff <= core_res;
      end else if (push) begin
         if (count_ff == 2'd0) slot0_ff <= core_res;
         else slot1_ff <= core_res;
      end
   end

   assign rsp_tvalid = (count_ff != 2'd0);
   assign rsp_tuser  = slot0_ff.has_byte;
   assign rsp_tlast  = slot0_ff.command_end;
   assign rsp_tdata  = {1'b0, slot0_ff.protocol_error, slot0_ff.command_ok,
                        slot0_ff.arg_end, slot0_ff.arg_index, slot0_ff.payload_byte};

   // A verdict of good only ever travels on a command-end transfer.
   a_ok_on_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[29]) |-> rsp_tlast)
      else $error("command_ok set without command_end");

   // An aborted parse never carries a payload byte or a good verdict.
   a_err_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[30]) |-> (!rsp_tuser && !rsp_tdata[29] && !rsp_tdata[28]))
      else $error("protocol error transfer carries data or verdict");

   // A result produced while the receiver stalls is held in the queue.
   a_result_kept: assert property (@(posedge clock) disable iff (reset)
      (core_valid && !pop) |=> (rsp_tvalid && (count_ff == $past(count_ff) + 2'd1)))
      else $error("result lost in output queue");

   // Payload bytes never coincide with an element-end marker.
   a_byte_not_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (!rsp_tdata[28] && !rsp_tlast))
      else $error("payload byte marked as element end");

endmodule
